// ===== hw/rtl/iso_dur_pkg.sv =====
// shared types, constants and a helper function for the iso 8601 duration parser
// no dependencies; the front end, queue, parser, accumulator and top level import it
package iso_dur_pkg;

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

  localparam logic [4:0]  MAX_DIGITS = 5'd19;
  localparam int          UNIT_W     = 30;
  localparam logic [UNIT_W-1:0] MS_WEEK   = 30'd604800000;
  localparam logic [UNIT_W-1:0] MS_DAY    = 30'd86400000;
  localparam logic [UNIT_W-1:0] MS_HOUR   = 30'd3600000;
  localparam logic [UNIT_W-1:0] MS_MINUTE = 30'd60000;
  localparam logic [UNIT_W-1:0] MS_SECOND = 30'd1000;

  typedef enum logic [3:0] {
    PH_EXPECT_P,
    PH_AFTER_P,
    PH_DATE_NUM,
    PH_AFTER_W,
    PH_AFTER_D,
    PH_AFTER_T,
    PH_TIME_NUM,
    PH_FRAC_START,
    PH_FRAC,
    PH_AFTER_SUFFIX
  } phase_t;

  typedef enum logic [3:0] {
    TK_DIGIT,
    TK_P,
    TK_T,
    TK_W,
    TK_D,
    TK_H,
    TK_M,
    TK_S,
    TK_DOT,
    TK_OTHER
  } tok_cls_t;

  typedef enum logic [2:0] {
    U_WEEK,
    U_DAY,
    U_HOUR,
    U_MINUTE,
    U_SECOND
  } unit_t;

  typedef struct packed {
    tok_cls_t   cls;
    logic [3:0] digit;
    logic       last;
  } token_t;

  typedef struct packed {
    logic        is_add;
    logic        is_end;
    logic        parse_ok;
    unit_t       unit;
    logic [62:0] number;
    logic [9:0]  frac;
  } add_op_t;

  function automatic logic [UNIT_W-1:0] unit_ms(unit_t u);
    logic [UNIT_W-1:0] r;
    case (u)
      U_WEEK:   r = MS_WEEK;
      U_DAY:    r = MS_DAY;
      U_HOUR:   r = MS_HOUR;
      U_MINUTE: r = MS_MINUTE;
      U_SECOND: r = MS_SECOND;
      default:  r = MS_SECOND;
    endcase
    return r;
  endfunction

endpackage

// ===== hw/rtl/iso_dur_if.sv =====
// valid/ready channel interfaces: character requests in, parse results out
// no dependencies
interface iso_dur_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] character;
  logic       last;

  modport source(output valid, character, last, input ready);
  modport sink(input valid, character, last, output ready);
endinterface

interface iso_dur_out_if;
  logic        valid;
  logic        ready;
  logic        valid_res;
  logic [62:0] milliseconds;

  modport source(output valid, valid_res, milliseconds, input ready);
  modport sink(input valid, valid_res, milliseconds, output ready);
endinterface

// ===== hw/rtl/iso_dur_front.sv =====
// front end: accepts characters and classifies them into tokens for the queue
// depends on iso_dur_pkg and iso_dur_in_if
module iso_dur_front (
  iso_dur_in_if.sink        text,
  input  logic              full,
  output logic              push,
  output iso_dur_pkg::token_t tok
);
  import iso_dur_pkg::*;

  logic [7:0] c;

  assign c          = text.character;
  assign text.ready = !full;
  assign push       = text.valid && !full;

  always_comb begin
    tok.last  = text.last;
    tok.digit = 4'(c - 8'h30);
    case (c)
      8'h50:   tok.cls = TK_P;
      8'h54:   tok.cls = TK_T;
      8'h57:   tok.cls = TK_W;
      8'h44:   tok.cls = TK_D;
      8'h48:   tok.cls = TK_H;
      8'h4D:   tok.cls = TK_M;
      8'h53:   tok.cls = TK_S;
      8'h2E:   tok.cls = TK_DOT;
      default: tok.cls = (c >= 8'h30 && c <= 8'h39) ? TK_DIGIT : TK_OTHER;
    endcase
  end

endmodule

// ===== hw/rtl/iso_dur_queue.sv =====
// short token queue between the front end and the parser
// depends on iso_dur_pkg
module iso_dur_queue (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  iso_dur_pkg::token_t push_tok,
  output logic                full,
  input  logic                pop,
  output logic                head_valid,
  output iso_dur_pkg::token_t head
);
  import iso_dur_pkg::*;

  token_t            mem [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QPTR_W:0]   count;
  logic              do_pop;

  assign full       = (count == (QPTR_W+1)'(QUEUE_DEPTH));
  assign head_valid = (count != '0);
  assign head       = mem[rd_ptr];
  assign do_pop     = pop && head_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (do_pop) rd_ptr <= rd_ptr + 1'b1;
      count <= count + (QPTR_W+1)'(push) - (QPTR_W+1)'(do_pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr] <= push_tok;
  end

endmodule

// ===== hw/rtl/iso_dur_back.sv =====
// parser: walks the duration grammar one token per cycle unless stalled, builds
// numbers and issues add and end requests to the accumulator; depends on iso_dur_pkg
module iso_dur_back (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 head_valid,
  input  iso_dur_pkg::token_t  head,
  output logic                 pop,
  output logic                 op_valid,
  output iso_dur_pkg::add_op_t op,
  input  logic                 op_ready
);
  import iso_dur_pkg::*;

  phase_t      phase, phase_next;
  logic [62:0] number_value, number_value_next;
  logic [4:0]  digit_count, digit_count_next;
  logic [9:0]  fraction_ms, fraction_ms_next;
  logic [1:0]  fraction_digits, fraction_digits_next;
  logic [1:0]  unit_stage, unit_stage_next;
  logic        decimal_seen, decimal_seen_next;
  logic        failed, failed_next;
  logic        op_valid_next;
  add_op_t     op_next;
  logic        emit;

  logic        take;
  logic [66:0] prod;
  logic [4:0]  dc_inc;
  logic        suffix_ok;
  unit_t       suffix_unit;
  logic [1:0]  suffix_stage;
  logic [9:0]  digit_w;

  assign take    = head_valid && (!op_valid || op_ready);
  assign pop     = take;
  assign digit_w = 10'(head.digit);
  assign prod    = ({4'd0, number_value} << 3) + ({4'd0, number_value} << 1)
                 + 67'(head.digit);
  assign dc_inc  = digit_count + 5'd1;

  // time unit suffix check
  always_comb begin
    suffix_ok    = 1'b0;
    suffix_unit  = U_SECOND;
    suffix_stage = unit_stage;
    if (head.cls == TK_H && unit_stage < 2'd1 && !decimal_seen) begin
      suffix_ok = 1'b1; suffix_unit = U_HOUR; suffix_stage = 2'd1;
    end else if (head.cls == TK_M && unit_stage < 2'd2 && !decimal_seen) begin
      suffix_ok = 1'b1; suffix_unit = U_MINUTE; suffix_stage = 2'd2;
    end else if (head.cls == TK_S && unit_stage < 2'd3) begin
      suffix_ok = 1'b1; suffix_unit = U_SECOND; suffix_stage = 2'd3;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= PH_EXPECT_P;
      number_value    <= '0;
      digit_count     <= '0;
      fraction_ms     <= '0;
      fraction_digits <= '0;
      unit_stage      <= '0;
      decimal_seen    <= 1'b0;
      failed          <= 1'b0;
      op_valid        <= 1'b0;
    end else begin
      phase           <= phase_next;
      number_value    <= number_value_next;
      digit_count     <= digit_count_next;
      fraction_ms     <= fraction_ms_next;
      fraction_digits <= fraction_digits_next;
      unit_stage      <= unit_stage_next;
      decimal_seen    <= decimal_seen_next;
      failed          <= failed_next;
      op_valid        <= op_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (take) op <= op_next;
  end

  always_comb begin
    phase_next           = phase;
    number_value_next    = number_value;
    digit_count_next     = digit_count;
    fraction_ms_next     = fraction_ms;
    fraction_digits_next = fraction_digits;
    unit_stage_next      = unit_stage;
    decimal_seen_next    = decimal_seen;
    failed_next          = failed;
    op_next.is_add       = 1'b0;
    op_next.is_end       = 1'b0;
    op_next.parse_ok     = 1'b0;
    op_next.unit         = U_SECOND;
    op_next.number       = number_value;
    op_next.frac         = '0;
    emit                 = 1'b0;

    if (take && !failed) begin
      case (phase)
        PH_EXPECT_P: begin
          if (head.cls == TK_P) phase_next = PH_AFTER_P;
          else failed_next = 1'b1;
        end
        PH_AFTER_P: begin
          if (head.cls == TK_T) begin
            phase_next = PH_AFTER_T;
          end else if (head.cls == TK_DIGIT) begin
            number_value_next    = 63'(head.digit);
            digit_count_next     = 5'd1;
            fraction_ms_next     = '0;
            fraction_digits_next = '0;
            decimal_seen_next    = 1'b0;
            phase_next           = PH_DATE_NUM;
          end else begin
            failed_next = 1'b1;
          end
        end
        PH_DATE_NUM: begin
          if (head.cls == TK_DIGIT) begin
            digit_count_next = dc_inc;
            if (dc_inc > MAX_DIGITS || prod[66:63] != 4'd0) failed_next = 1'b1;
            else number_value_next = prod[62:0];
          end else if (head.cls == TK_W || head.cls == TK_D) begin
            emit           = 1'b1;
            op_next.is_add = 1'b1;
            op_next.unit   = (head.cls == TK_W) ? U_WEEK : U_DAY;
            phase_next     = (head.cls == TK_W) ? PH_AFTER_W : PH_AFTER_D;
          end else begin
            failed_next = 1'b1;
          end
        end
        PH_AFTER_D: begin
          if (head.cls == TK_T) phase_next = PH_AFTER_T;
          else failed_next = 1'b1;
        end
        PH_AFTER_T, PH_AFTER_SUFFIX: begin
          if (head.cls == TK_DIGIT) begin
            number_value_next    = 63'(head.digit);
            digit_count_next     = 5'd1;
            fraction_ms_next     = '0;
            fraction_digits_next = '0;
            decimal_seen_next    = 1'b0;
            phase_next           = PH_TIME_NUM;
          end else begin
            failed_next = 1'b1;
          end
        end
        PH_TIME_NUM, PH_FRAC: begin
          if (head.cls == TK_DIGIT && phase == PH_TIME_NUM) begin
            digit_count_next = dc_inc;
            if (dc_inc > MAX_DIGITS || prod[66:63] != 4'd0) failed_next = 1'b1;
            else number_value_next = prod[62:0];
          end else if (head.cls == TK_DIGIT) begin
            if (fraction_digits >= 2'd3) begin
              failed_next = 1'b1;
            end else begin
              fraction_ms_next     = fraction_ms
                                   + ((fraction_digits == 2'd1) ? digit_w * 10'd10 : digit_w);
              fraction_digits_next = fraction_digits + 2'd1;
            end
          end else if (head.cls == TK_DOT && phase == PH_TIME_NUM) begin
            decimal_seen_next = 1'b1;
            phase_next        = PH_FRAC_START;
          end else if (suffix_ok) begin
            emit              = 1'b1;
            op_next.is_add    = 1'b1;
            op_next.unit      = suffix_unit;
            op_next.frac      = decimal_seen ? fraction_ms : 10'd0;
            unit_stage_next   = suffix_stage;
            decimal_seen_next = 1'b0;
            phase_next        = PH_AFTER_SUFFIX;
          end else begin
            failed_next = 1'b1;
          end
        end
        PH_FRAC_START: begin
          if (head.cls == TK_DIGIT) begin
            fraction_ms_next     = digit_w * 10'd100;
            fraction_digits_next = 2'd1;
            phase_next           = PH_FRAC;
          end else begin
            failed_next = 1'b1;
          end
        end
        default: failed_next = 1'b1;
      endcase
    end

    // end of string: report and return to the reset state
    if (take && head.last) begin
      emit             = 1'b1;
      op_next.is_end   = 1'b1;
      op_next.parse_ok = !failed_next && (phase_next == PH_AFTER_W
                         || phase_next == PH_AFTER_D || phase_next == PH_AFTER_SUFFIX);
      phase_next           = PH_EXPECT_P;
      number_value_next    = '0;
      digit_count_next     = '0;
      fraction_ms_next     = '0;
      fraction_digits_next = '0;
      unit_stage_next      = '0;
      decimal_seen_next    = 1'b0;
      failed_next          = 1'b0;
    end

    op_valid_next = take ? emit : (op_valid && !op_ready);
  end

endmodule

// ===== hw/rtl/iso_dur_accum.sv =====
// accumulator: split multiply of number by unit, overflow-checked add to the
// running total, and the result register; depends on iso_dur_pkg, iso_dur_out_if
module iso_dur_accum (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 op_valid,
  input  iso_dur_pkg::add_op_t op,
  output logic                 op_ready,
  iso_dur_out_if.source        result
);
  import iso_dur_pkg::*;

  logic [UNIT_W-1:0] unit_val;

  logic        s2_valid;
  logic        s2_is_add;
  logic        s2_is_end;
  logic        s2_parse_ok;
  logic [60:0] pp_hi;
  logic [61:0] pp_lo;
  logic [9:0]  s2_frac;

  logic [62:0] total, total_next;
  logic        acc_failed, acc_failed_next;
  logic [94:0] sum;
  logic        ovf;
  logic        s2_adv;
  logic        res_ok;

  logic        res_valid;
  logic        res_flag;
  logic [62:0] res_ms;

  assign unit_val = unit_ms(op.unit);
  assign s2_adv   = s2_valid && (!s2_is_end || !res_valid || result.ready);
  assign op_ready = !s2_valid || s2_adv;

  assign sum = 95'(total) + 95'(s2_frac) + (95'(pp_hi) << 32) + 95'(pp_lo);
  assign ovf = (sum[94:63] != '0);

  always_comb begin
    total_next      = total;
    acc_failed_next = acc_failed;
    if (s2_is_add) begin
      if (ovf) acc_failed_next = 1'b1;
      else if (!acc_failed) total_next = sum[62:0];
    end
    res_ok = s2_parse_ok && !acc_failed_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid   <= 1'b0;
      res_valid  <= 1'b0;
      total      <= '0;
      acc_failed <= 1'b0;
    end else begin
      if (op_ready) s2_valid <= op_valid;
      if (s2_adv && s2_is_end) res_valid <= 1'b1;
      else if (result.ready) res_valid <= 1'b0;
      if (s2_adv) begin
        if (s2_is_end) begin
          total      <= '0;
          acc_failed <= 1'b0;
        end else begin
          total      <= total_next;
          acc_failed <= acc_failed_next;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (op_ready && op_valid) begin
      s2_is_add   <= op.is_add;
      s2_is_end   <= op.is_end;
      s2_parse_ok <= op.parse_ok;
      s2_frac     <= op.frac;
      pp_hi       <= op.is_add ? 61'(op.number[62:32] * unit_val) : '0;
      pp_lo       <= op.is_add ? 62'(op.number[31:0] * unit_val) : '0;
    end
    if (s2_adv && s2_is_end) begin
      res_flag <= res_ok;
      res_ms   <= res_ok ? total_next : '0;
    end
  end

  assign result.valid        = res_valid;
  assign result.valid_res    = res_flag;
  assign result.milliseconds = res_ms;

endmodule

// ===== hw/rtl/iso8601_duration_to_ms.sv =====
// iso 8601 duration to milliseconds; accepts one character per cycle unless the queue is full
// after the final character is accepted, a result passes through the queue, parser,
// multiply and accumulate registers in turn; a stalled result does not stop intake
// until the four-entry queue and the pipeline fill
// synchronous reset empties the queue and returns the parser to expecting P
module iso8601_duration_to_ms (
  input logic           clk,
  input logic           rst,
  iso_dur_in_if.sink    text,
  iso_dur_out_if.source result
);
  import iso_dur_pkg::*;

  logic    push;
  token_t  push_tok;
  logic    full;
  logic    pop;
  logic    head_valid;
  token_t  head;
  logic    op_valid;
  logic    op_ready;
  add_op_t op;

  iso_dur_front u_front (
    .text (text),
    .full (full),
    .push (push),
    .tok  (push_tok)
  );

  iso_dur_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_tok   (push_tok),
    .full       (full),
    .pop        (pop),
    .head_valid (head_valid),
    .head       (head)
  );

  iso_dur_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (head_valid),
    .head       (head),
    .pop        (pop),
    .op_valid   (op_valid),
    .op         (op),
    .op_ready   (op_ready)
  );

  iso_dur_accum u_accum (
    .clk      (clk),
    .rst      (rst),
    .op_valid (op_valid),
    .op       (op),
    .op_ready (op_ready),
    .result   (result)
  );

endmodule

// ===== hw/rtl/iso_dur_checker.sv =====
// port-level checks for iso8601_duration_to_ms, bound to the top level
// no package dependency
module iso_dur_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input logic        in_last,
  input logic        out_valid,
  input logic        out_ready,
  input logic        valid_res,
  input logic [62:0] milliseconds
);

  logic [3:0] pending;
  logic       in_end;
  logic       out_acc;

  assign in_end  = in_valid && in_ready && in_last;
  assign out_acc = out_valid && out_ready;

  // strings ended but not yet reported
  always_ff @(posedge clk) begin
    if (rst) pending <= '0;
    else pending <= pending + 4'(in_end) - 4'(out_acc);
  end

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(valid_res) && $stable(milliseconds))
    else $error("result changed while stalled");

  a_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !valid_res |-> milliseconds == 63'd0)
    else $error("invalid result with nonzero milliseconds");

  a_caused: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> pending != 4'd0)
    else $error("result without a finished string");

  a_reset: assert property (@(posedge clk) !rst && $past(rst) |-> !out_valid)
    else $error("result shown right after reset");

endmodule

bind iso8601_duration_to_ms iso_dur_checker u_checker (
  .clk          (clk),
  .rst          (rst),
  .in_valid     (text.valid),
  .in_ready     (text.ready),
  .in_last      (text.last),
  .out_valid    (result.valid),
  .out_ready    (result.ready),
  .valid_res    (result.valid_res),
  .milliseconds (result.milliseconds)
);
